FILE: hdl/tle_pkg.sv
`default_nettype none

package tle_pkg;

  localparam int COORD_W    = 16;
  localparam int ABS_W      = 16;
  localparam int SQ_W       = 2 * ABS_W;
  localparam int SUM_W      = SQ_W + 1;
  localparam int LEN_SHIFT  = 16;
  localparam int SQRT_IN_W  = SUM_W + LEN_SHIFT + 1;
  localparam int SQRT_STEPS = 25;
  localparam int LEN_W      = 25;

  localparam int THICK_W    = 12;
  localparam int SIZE_W     = 13;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 13;
  localparam int T_SHIFT    = 11;
  localparam int T_W        = THICK_W + T_SHIFT;
  localparam int MAG_W      = ABS_W + T_W;
  localparam int OFFN_W     = MAG_W + 1;

  localparam int QUO_W      = 17;
  localparam int OFF_W      = QUO_W + 1;
  localparam int PIX_SHIFT  = 4;
  localparam int PIX_W      = 22;
  localparam int HALF_SHIFT = 7;
  localparam int HALF_W     = SIZE_W + HALF_SHIFT;
  localparam int DIFF_W     = PIX_W + 1;
  localparam int NDC_FRAC_BITS = 14;
  localparam int NDCN_W     = DIFF_W + NDC_FRAC_BITS;
  localparam int OUT_W      = 16;

  localparam int DIV_N_W    = (NDCN_W > OFFN_W) ? NDCN_W : OFFN_W;
  localparam int DIV_D_W    = (LEN_W > HALF_W) ? LEN_W : HALF_W;
  localparam int DIV_R_W    = (DIV_N_W > DIV_D_W + QUO_W) ? DIV_N_W : DIV_D_W + QUO_W;

  localparam logic [CFG_IDX_W-1:0] CFG_THICKNESS = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_SCREEN_W  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_SCREEN_H  = 2'd2;

  localparam logic [THICK_W-1:0] THICK_RST  = 12'd16;
  localparam logic [SIZE_W-1:0]  SCR_W_RST  = 13'd1024;
  localparam logic [SIZE_W-1:0]  SCR_H_RST  = 13'd768;
  localparam logic [SIZE_W-1:0]  SCR_MIN    = 13'd2;

  localparam int VTX_W = 3;
  localparam logic [VTX_W-1:0] VTX_FIRST = 3'd0;
  localparam logic [VTX_W-1:0] VTX_LAST  = 3'd5;

  localparam logic [1:0] CORNER_0 = 2'd0;
  localparam logic [1:0] CORNER_1 = 2'd1;
  localparam logic [1:0] CORNER_2 = 2'd2;

  typedef struct packed {
    logic signed [COORD_W-1:0] ax;
    logic signed [COORD_W-1:0] ay;
    logic signed [COORD_W-1:0] bx;
    logic signed [COORD_W-1:0] by;
    logic [ABS_W-1:0]          adx;
    logic [ABS_W-1:0]          ady;
    logic                      negx;
    logic                      negy;
    logic                      degen;
  } sq_side_t;

  typedef struct packed {
    logic signed [COORD_W-1:0] ax;
    logic signed [COORD_W-1:0] ay;
    logic signed [COORD_W-1:0] bx;
    logic signed [COORD_W-1:0] by;
    logic                      negx;
    logic                      negy;
    logic                      degen;
  } off_side_t;

  typedef struct packed {
    logic       tri_idx;
    logic [1:0] corner;
    logic       degen;
    logic       last;
    logic       negx;
    logic       negy;
    logic       ovfx;
    logic       ovfy;
  } ndc_side_t;

  localparam int DIV_SIDE_W = ($bits(off_side_t) > $bits(ndc_side_t)) ?
                              $bits(off_side_t) : $bits(ndc_side_t);

  typedef struct packed {
    logic signed [COORD_W-1:0] ax;
    logic signed [COORD_W-1:0] ay;
    logic signed [COORD_W-1:0] bx;
    logic signed [COORD_W-1:0] by;
    logic signed [OFF_W-1:0]   ox;
    logic signed [OFF_W-1:0]   oy;
    logic                      degen;
  } exp_item_t;

  typedef struct packed {
    logic       use_b;
    logic       plus;
    logic       tri_idx;
    logic [1:0] corner;
    logic       last;
  } vsel_t;

  typedef struct packed {
    logic signed [PIX_W-1:0] vx;
    logic signed [PIX_W-1:0] vy;
    logic                    tri_idx;
    logic [1:0]              corner;
    logic                    degen;
    logic                    last;
  } vtx_t;

  // triangle 0: A-D, A+D, B-D; triangle 1: A+D, B-D, B+D
  function automatic vsel_t vtx_sel(input logic [VTX_W-1:0] k);
    vsel_t s;
    s = '0;
    unique case (k)
      3'd0: s = '{use_b: 1'b0, plus: 1'b0, tri_idx: 1'b0, corner: CORNER_0, last: 1'b0};
      3'd1: s = '{use_b: 1'b0, plus: 1'b1, tri_idx: 1'b0, corner: CORNER_1, last: 1'b0};
      3'd2: s = '{use_b: 1'b1, plus: 1'b0, tri_idx: 1'b0, corner: CORNER_2, last: 1'b0};
      3'd3: s = '{use_b: 1'b0, plus: 1'b1, tri_idx: 1'b1, corner: CORNER_0, last: 1'b0};
      3'd4: s = '{use_b: 1'b1, plus: 1'b0, tri_idx: 1'b1, corner: CORNER_1, last: 1'b0};
      3'd5: s = '{use_b: 1'b1, plus: 1'b1, tri_idx: 1'b1, corner: CORNER_2, last: 1'b1};
      default: s = '0;
    endcase
    return s;
  endfunction

endpackage

`default_nettype wire

FILE: hdl/thick_line_triangle_expander.sv
// Channel  | Handshake                 | Payload
// cfg      | cfg_we_i                  | cfg_idx_i, cfg_wdata_i
// line in  | in_valid_i / in_ready_o   | start_x_i, start_y_i, end_x_i, end_y_i
// vertex   | out_valid_o / out_ready_i | vertex_x_o, vertex_y_o, triangle_index_o,
//          |                           | corner_index_o, degenerate_o, last_o
//
// Six vertices per line leave through one output register as later lines enter.
// Line path: 3 setup stages, 25-stage square root, 2 stages, 17-stage divider.
// Vertex path: 3 stages, 17-stage divider, output register. Reset loads the default
// registers and clears valids. An output stall holds the vertex path in place; the
// line path keeps accepting until a line waits at the divider output.
`default_nettype none

module thick_line_triangle_expander (
  input  wire logic                                clk_i,
  input  wire logic                                rst_ni,
  input  wire logic                                cfg_we_i,
  input  wire logic [tle_pkg::CFG_IDX_W-1:0]       cfg_idx_i,
  input  wire logic [tle_pkg::CFG_DATA_W-1:0]      cfg_wdata_i,
  input  wire logic                                in_valid_i,
  output logic                                     in_ready_o,
  input  wire logic signed [tle_pkg::COORD_W-1:0]  start_x_i,
  input  wire logic signed [tle_pkg::COORD_W-1:0]  start_y_i,
  input  wire logic signed [tle_pkg::COORD_W-1:0]  end_x_i,
  input  wire logic signed [tle_pkg::COORD_W-1:0]  end_y_i,
  output logic                                     out_valid_o,
  input  wire logic                                out_ready_i,
  output logic signed [tle_pkg::OUT_W-1:0]         vertex_x_o,
  output logic signed [tle_pkg::OUT_W-1:0]         vertex_y_o,
  output logic                                     triangle_index_o,
  output logic [1:0]                               corner_index_o,
  output logic                                     degenerate_o,
  output logic                                     last_o
);

  localparam int CW = tle_pkg::COORD_W;
  localparam int QW = tle_pkg::QUO_W;
  localparam int OW = tle_pkg::OUT_W;
  localparam logic [QW-1:0] Q_MAX = QW'(2 ** (OW - 1) - 1);
  localparam logic [QW-1:0] Q_MIN = QW'(2 ** (OW - 1));
  localparam logic signed [OW-1:0] SAT_HI = OW'(2 ** (OW - 1) - 1);
  localparam logic signed [OW-1:0] SAT_LO = OW'(2 ** (OW - 1));

  // configuration
  logic [tle_pkg::THICK_W-1:0] thick_q;
  logic [tle_pkg::SIZE_W-1:0]  scr_w_q, scr_h_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      thick_q <= tle_pkg::THICK_RST;
      scr_w_q <= tle_pkg::SCR_W_RST;
      scr_h_q <= tle_pkg::SCR_H_RST;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        tle_pkg::CFG_THICKNESS: thick_q <= cfg_wdata_i[tle_pkg::THICK_W-1:0];
        tle_pkg::CFG_SCREEN_W:  scr_w_q <= cfg_wdata_i[tle_pkg::SIZE_W-1:0];
        tle_pkg::CFG_SCREEN_H:  scr_h_q <= cfg_wdata_i[tle_pkg::SIZE_W-1:0];
        default: ;
      endcase
    end
  end

  logic [tle_pkg::T_W-1:0]    t_scaled;
  logic [tle_pkg::SIZE_W-1:0] scr_w_eff, scr_h_eff;
  logic [tle_pkg::HALF_W-1:0] half_w, half_h;

  assign t_scaled  = tle_pkg::T_W'(thick_q) << tle_pkg::T_SHIFT;
  assign scr_w_eff = (scr_w_q < tle_pkg::SCR_MIN) ? tle_pkg::SCR_MIN : scr_w_q;
  assign scr_h_eff = (scr_h_q < tle_pkg::SCR_MIN) ? tle_pkg::SCR_MIN : scr_h_q;
  assign half_w    = tle_pkg::HALF_W'(scr_w_eff) << tle_pkg::HALF_SHIFT;
  assign half_h    = tle_pkg::HALF_W'(scr_h_eff) << tle_pkg::HALF_SHIFT;

  // line path
  logic en_f, exp_take, fd_valid;

  logic                f1_valid_q, f2_valid_q, f3_valid_q, f4_valid_q, f5_valid_q;
  tle_pkg::sq_side_t   f1_side_q, f2_side_q, f3_side_q, f1_side_d;
  logic signed [CW:0]  dx_d, dy_d;
  logic [tle_pkg::SQ_W-1:0]      sqx_q, sqy_q;
  logic [tle_pkg::SQRT_IN_W-1:0] rad_q;

  assign en_f       = !fd_valid || exp_take;
  assign in_ready_o = en_f;

  always_comb begin
    dx_d            = (CW+1)'(end_x_i) - (CW+1)'(start_x_i);
    dy_d            = (CW+1)'(end_y_i) - (CW+1)'(start_y_i);
    f1_side_d.ax    = start_x_i;
    f1_side_d.ay    = start_y_i;
    f1_side_d.bx    = end_x_i;
    f1_side_d.by    = end_y_i;
    f1_side_d.adx   = dx_d[CW] ? CW'(-dx_d) : CW'(dx_d);
    f1_side_d.ady   = dy_d[CW] ? CW'(-dy_d) : CW'(dy_d);
    f1_side_d.negx  = !dy_d[CW];
    f1_side_d.negy  = dx_d[CW];
    f1_side_d.degen = (dx_d == '0) && (dy_d == '0);
  end

  logic                          sq_valid;
  logic [tle_pkg::LEN_W-1:0]     sq_len, len_q, den_f_q;
  tle_pkg::sq_side_t             sq_side;
  tle_pkg::off_side_t            f4_side_q, f5_side_q;
  logic [tle_pkg::MAG_W-1:0]     magx_q, magy_q;
  logic [tle_pkg::DIV_N_W-1:0]   numx_f_q, numy_f_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      f1_valid_q <= 1'b0;
      f2_valid_q <= 1'b0;
      f3_valid_q <= 1'b0;
      f4_valid_q <= 1'b0;
      f5_valid_q <= 1'b0;
    end else if (en_f) begin
      f1_valid_q <= in_valid_i;
      f2_valid_q <= f1_valid_q;
      f3_valid_q <= f2_valid_q;
      f4_valid_q <= sq_valid;
      f5_valid_q <= f4_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_f) begin
      f1_side_q <= f1_side_d;
      f2_side_q <= f1_side_q;
      sqx_q     <= f1_side_q.adx * f1_side_q.adx;
      sqy_q     <= f1_side_q.ady * f1_side_q.ady;
      f3_side_q <= f2_side_q;
      rad_q     <= tle_pkg::SQRT_IN_W'(tle_pkg::SUM_W'(sqx_q) + tle_pkg::SUM_W'(sqy_q))
                   << tle_pkg::LEN_SHIFT;
      f4_side_q <= '{ax: sq_side.ax, ay: sq_side.ay, bx: sq_side.bx, by: sq_side.by,
                     negx: sq_side.negx, negy: sq_side.negy, degen: sq_side.degen};
      len_q     <= sq_len;
      magx_q    <= tle_pkg::MAG_W'(sq_side.ady) * tle_pkg::MAG_W'(t_scaled);
      magy_q    <= tle_pkg::MAG_W'(sq_side.adx) * tle_pkg::MAG_W'(t_scaled);
      f5_side_q <= f4_side_q;
      numx_f_q  <= tle_pkg::DIV_N_W'(magx_q) + tle_pkg::DIV_N_W'(len_q >> 1);
      numy_f_q  <= tle_pkg::DIV_N_W'(magy_q) + tle_pkg::DIV_N_W'(len_q >> 1);
      den_f_q   <= len_q;
    end
  end

  tle_sqrt u_sqrt (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en_f),
    .valid_i (f3_valid_q),
    .rad_i   (rad_q),
    .side_i  (f3_side_q),
    .valid_o (sq_valid),
    .root_o  (sq_len),
    .side_o  (sq_side)
  );

  logic [QW-1:0]                  fqx, fqy;
  logic [tle_pkg::DIV_SIDE_W-1:0] fd_side_vec;
  tle_pkg::off_side_t             fd_side;

  tle_div u_div_off (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en_f),
    .valid_i (f5_valid_q),
    .num_a_i (numx_f_q),
    .den_a_i (tle_pkg::DIV_D_W'(den_f_q)),
    .num_b_i (numy_f_q),
    .den_b_i (tle_pkg::DIV_D_W'(den_f_q)),
    .side_i  (tle_pkg::DIV_SIDE_W'(f5_side_q)),
    .valid_o (fd_valid),
    .quo_a_o (fqx),
    .quo_b_o (fqy),
    .side_o  (fd_side_vec)
  );

  assign fd_side = tle_pkg::off_side_t'(fd_side_vec[$bits(tle_pkg::off_side_t)-1:0]);

  tle_pkg::exp_item_t item;
  logic signed [tle_pkg::OFF_W-1:0] qx_s, qy_s;

  assign qx_s = $signed({1'b0, fqx});
  assign qy_s = $signed({1'b0, fqy});

  always_comb begin
    item.ax    = fd_side.ax;
    item.ay    = fd_side.ay;
    item.bx    = fd_side.bx;
    item.by    = fd_side.by;
    item.degen = fd_side.degen;
    item.ox    = fd_side.degen ? '0 : (fd_side.negx ? -qx_s : qx_s);
    item.oy    = fd_side.degen ? '0 : (fd_side.negy ? -qy_s : qy_s);
  end

  // vertex path
  logic          en_b, exp_valid, out_valid_q;
  tle_pkg::vtx_t exp_vtx;

  assign en_b = !out_valid_q || out_ready_i;

  tle_expand u_expand (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (fd_valid),
    .item_i  (item),
    .adv_i   (en_b),
    .take_o  (exp_take),
    .valid_o (exp_valid),
    .vtx_o   (exp_vtx)
  );

  logic                              b1_valid_q, b2_valid_q, b3_valid_q;
  tle_pkg::vtx_t                     b1_vtx_q;
  logic signed [tle_pkg::DIFF_W-1:0] diffx_d, diffy_d;
  logic [tle_pkg::DIFF_W-2:0]        absx_q, absy_q;
  tle_pkg::ndc_side_t                b2_side_q, b3_side_q, b2_side_d, b3_side_d;
  logic [tle_pkg::NDCN_W-1:0]        nx_d, ny_d, nx_q, ny_q;

  always_comb begin
    diffx_d = tle_pkg::DIFF_W'(b1_vtx_q.vx) - $signed({1'b0, half_w});
    diffy_d = tle_pkg::DIFF_W'(b1_vtx_q.vy) - $signed({1'b0, half_h});
    b2_side_d.tri_idx = b1_vtx_q.tri_idx;
    b2_side_d.corner  = b1_vtx_q.corner;
    b2_side_d.degen   = b1_vtx_q.degen;
    b2_side_d.last    = b1_vtx_q.last;
    b2_side_d.negx    = diffx_d[tle_pkg::DIFF_W-1];
    b2_side_d.negy    = diffy_d[tle_pkg::DIFF_W-1];
    b2_side_d.ovfx    = 1'b0;
    b2_side_d.ovfy    = 1'b0;
  end

  always_comb begin
    nx_d = (tle_pkg::NDCN_W'(absx_q) << tle_pkg::NDC_FRAC_BITS)
           + tle_pkg::NDCN_W'(half_w >> 1);
    ny_d = (tle_pkg::NDCN_W'(absy_q) << tle_pkg::NDC_FRAC_BITS)
           + tle_pkg::NDCN_W'(half_h >> 1);
    b3_side_d      = b2_side_q;
    b3_side_d.ovfx = (nx_d >> QW) >= tle_pkg::NDCN_W'(half_w);
    b3_side_d.ovfy = (ny_d >> QW) >= tle_pkg::NDCN_W'(half_h);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      b1_valid_q <= 1'b0;
      b2_valid_q <= 1'b0;
      b3_valid_q <= 1'b0;
    end else if (en_b) begin
      b1_valid_q <= exp_valid;
      b2_valid_q <= b1_valid_q;
      b3_valid_q <= b2_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_b) begin
      b1_vtx_q  <= exp_vtx;
      absx_q    <= diffx_d[tle_pkg::DIFF_W-1] ? (tle_pkg::DIFF_W-1)'(-diffx_d)
                                             : (tle_pkg::DIFF_W-1)'(diffx_d);
      absy_q    <= diffy_d[tle_pkg::DIFF_W-1] ? (tle_pkg::DIFF_W-1)'(-diffy_d)
                                             : (tle_pkg::DIFF_W-1)'(diffy_d);
      b2_side_q <= b2_side_d;
      nx_q      <= nx_d;
      ny_q      <= ny_d;
      b3_side_q <= b3_side_d;
    end
  end

  logic                           bd_valid;
  logic [QW-1:0]                  bqx, bqy;
  logic [tle_pkg::DIV_SIDE_W-1:0] bd_side_vec;
  tle_pkg::ndc_side_t             bd_side;

  tle_div u_div_ndc (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en_b),
    .valid_i (b3_valid_q),
    .num_a_i (tle_pkg::DIV_N_W'(nx_q)),
    .den_a_i (tle_pkg::DIV_D_W'(half_w)),
    .num_b_i (tle_pkg::DIV_N_W'(ny_q)),
    .den_b_i (tle_pkg::DIV_D_W'(half_h)),
    .side_i  (tle_pkg::DIV_SIDE_W'(b3_side_q)),
    .valid_o (bd_valid),
    .quo_a_o (bqx),
    .quo_b_o (bqy),
    .side_o  (bd_side_vec)
  );

  assign bd_side = tle_pkg::ndc_side_t'(bd_side_vec[$bits(tle_pkg::ndc_side_t)-1:0]);

  function automatic logic signed [OW-1:0] ndc_sat(input logic [QW-1:0] q,
                                                   input logic neg, input logic ovf);
    logic signed [OW-1:0] r;
    if (ovf) begin
      r = neg ? SAT_LO : SAT_HI;
    end else if (!neg) begin
      r = (q > Q_MAX) ? SAT_HI : OW'(q);
    end else begin
      r = (q > Q_MIN) ? SAT_LO : OW'(-q);
    end
    return r;
  endfunction

  logic signed [OW-1:0] vx_q, vy_q;
  logic                 tri_q, degen_q, last_q;
  logic [1:0]           corner_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (en_b) begin
      out_valid_q <= bd_valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_b) begin
      vx_q     <= ndc_sat(bqx, bd_side.negx, bd_side.ovfx);
      vy_q     <= ndc_sat(bqy, bd_side.negy, bd_side.ovfy);
      tri_q    <= bd_side.tri_idx;
      corner_q <= bd_side.corner;
      degen_q  <= bd_side.degen;
      last_q   <= bd_side.last;
    end
  end

  assign out_valid_o      = out_valid_q;
  assign vertex_x_o       = vx_q;
  assign vertex_y_o       = vy_q;
  assign triangle_index_o = tri_q;
  assign corner_index_o   = corner_q;
  assign degenerate_o     = degen_q;
  assign last_o           = last_q;

`ifndef ASSERT_OFF
  a_last_is_final_corner: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && last_o |-> triangle_index_o && corner_index_o == tle_pkg::CORNER_2)
    else $error("last vertex not on final corner");

  a_ready_when_drained: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !fd_valid |-> in_ready_o)
    else $error("line path blocked while empty at its end");

  a_expander_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    exp_valid && !en_b |=> exp_valid)
    else $error("expander dropped a vertex during stall");
`endif

endmodule

`default_nettype wire

FILE: hdl/tle_sqrt.sv
`default_nettype none

// one result bit per stage
module tle_sqrt (
  input  wire logic                               clk_i,
  input  wire logic                               rst_ni,
  input  wire logic                               en_i,
  input  wire logic                               valid_i,
  input  wire logic [tle_pkg::SQRT_IN_W-1:0]      rad_i,
  input  wire tle_pkg::sq_side_t                  side_i,
  output logic                                    valid_o,
  output logic [tle_pkg::LEN_W-1:0]               root_o,
  output tle_pkg::sq_side_t                       side_o
);

  localparam int N = tle_pkg::SQRT_STEPS;
  localparam int W = tle_pkg::SQRT_IN_W;

  logic              valid_q [N];
  logic [W-1:0]      rem_q   [N];
  logic [W-1:0]      root_q  [N];
  tle_pkg::sq_side_t side_q  [N];

  for (genvar k = 0; k < N; k++) begin : g_step
    localparam logic [W-1:0] BIT = W'(1) << (2 * (N - 1 - k));
    logic              valid_in;
    logic [W-1:0]      rem_in, root_in, trial, rem_d, root_d;
    tle_pkg::sq_side_t side_in;

    if (k == 0) begin : g_first
      assign valid_in = valid_i;
      assign rem_in   = rad_i;
      assign root_in  = '0;
      assign side_in  = side_i;
    end else begin : g_next
      assign valid_in = valid_q[k-1];
      assign rem_in   = rem_q[k-1];
      assign root_in  = root_q[k-1];
      assign side_in  = side_q[k-1];
    end

    assign trial = root_in + BIT;

    always_comb begin
      if (rem_in >= trial) begin
        rem_d  = rem_in - trial;
        root_d = (root_in >> 1) + BIT;
      end else begin
        rem_d  = rem_in;
        root_d = root_in >> 1;
      end
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        valid_q[k] <= 1'b0;
      end else if (en_i) begin
        valid_q[k] <= valid_in;
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        rem_q[k]  <= rem_d;
        root_q[k] <= root_d;
        side_q[k] <= side_in;
      end
    end
  end

  assign valid_o = valid_q[N-1];
  assign root_o  = root_q[N-1][tle_pkg::LEN_W-1:0];
  assign side_o  = side_q[N-1];

endmodule

`default_nettype wire

FILE: hdl/tle_div.sv
`default_nettype none

// two-lane restoring divider, one quotient bit per stage
module tle_div (
  input  wire logic                              clk_i,
  input  wire logic                              rst_ni,
  input  wire logic                              en_i,
  input  wire logic                              valid_i,
  input  wire logic [tle_pkg::DIV_N_W-1:0]       num_a_i,
  input  wire logic [tle_pkg::DIV_D_W-1:0]       den_a_i,
  input  wire logic [tle_pkg::DIV_N_W-1:0]       num_b_i,
  input  wire logic [tle_pkg::DIV_D_W-1:0]       den_b_i,
  input  wire logic [tle_pkg::DIV_SIDE_W-1:0]    side_i,
  output logic                                   valid_o,
  output logic [tle_pkg::QUO_W-1:0]              quo_a_o,
  output logic [tle_pkg::QUO_W-1:0]              quo_b_o,
  output logic [tle_pkg::DIV_SIDE_W-1:0]         side_o
);

  localparam int N  = tle_pkg::QUO_W;
  localparam int RW = tle_pkg::DIV_R_W;
  localparam int DW = tle_pkg::DIV_D_W;

  logic                           valid_q [N];
  logic [RW-1:0]                  rem_q   [N][2];
  logic [DW-1:0]                  den_q   [N][2];
  logic [N-1:0]                   quo_q   [N][2];
  logic [tle_pkg::DIV_SIDE_W-1:0] side_q  [N];

  for (genvar k = 0; k < N; k++) begin : g_step
    localparam int SH = N - 1 - k;
    logic                           valid_in;
    logic [tle_pkg::DIV_SIDE_W-1:0] side_in;

    if (k == 0) begin : g_first
      assign valid_in = valid_i;
      assign side_in  = side_i;
    end else begin : g_next
      assign valid_in = valid_q[k-1];
      assign side_in  = side_q[k-1];
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        valid_q[k] <= 1'b0;
      end else if (en_i) begin
        valid_q[k] <= valid_in;
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        side_q[k] <= side_in;
      end
    end

    for (genvar l = 0; l < 2; l++) begin : g_lane
      logic [RW-1:0] rem_in, trial, rem_d;
      logic [DW-1:0] den_in;
      logic [N-1:0]  quo_in, quo_d;

      if (k == 0) begin : g_first
        assign rem_in = (l == 0) ? RW'(num_a_i) : RW'(num_b_i);
        assign den_in = (l == 0) ? den_a_i : den_b_i;
        assign quo_in = '0;
      end else begin : g_next
        assign rem_in = rem_q[k-1][l];
        assign den_in = den_q[k-1][l];
        assign quo_in = quo_q[k-1][l];
      end

      assign trial = RW'(den_in) << SH;

      always_comb begin
        rem_d = rem_in;
        quo_d = quo_in;
        if (rem_in >= trial) begin
          rem_d     = rem_in - trial;
          quo_d[SH] = 1'b1;
        end
      end

      always_ff @(posedge clk_i) begin
        if (en_i) begin
          rem_q[k][l] <= rem_d;
          den_q[k][l] <= den_in;
          quo_q[k][l] <= quo_d;
        end
      end
    end
  end

  assign valid_o = valid_q[N-1];
  assign quo_a_o = quo_q[N-1][0];
  assign quo_b_o = quo_q[N-1][1];
  assign side_o  = side_q[N-1];

endmodule

`default_nettype wire

FILE: hdl/tle_expand.sv
`default_nettype none

// holds one line and issues its six vertices
module tle_expand (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               valid_i,
  input  wire tle_pkg::exp_item_t item_i,
  input  wire logic               adv_i,
  output logic                    take_o,
  output logic                    valid_o,
  output tle_pkg::vtx_t           vtx_o
);

  logic                        busy_q, busy_d;
  logic [tle_pkg::VTX_W-1:0]   cnt_q, cnt_d;
  tle_pkg::exp_item_t          item_q;
  tle_pkg::vsel_t              sel;
  logic                        emit;
  logic signed [tle_pkg::PIX_W-1:0] base_x, base_y, off_x, off_y;

  assign emit   = busy_q && adv_i;
  assign take_o = valid_i && (!busy_q || (emit && cnt_q == tle_pkg::VTX_LAST));

  always_comb begin
    busy_d = busy_q;
    cnt_d  = cnt_q;
    priority if (take_o) begin
      busy_d = 1'b1;
      cnt_d  = tle_pkg::VTX_FIRST;
    end else if (emit && cnt_q == tle_pkg::VTX_LAST) begin
      busy_d = 1'b0;
    end else if (emit) begin
      cnt_d = cnt_q + 1'b1;
    end else begin
      busy_d = busy_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= tle_pkg::VTX_FIRST;
    end else begin
      busy_q <= busy_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (take_o) begin
      item_q <= item_i;
    end
  end

  assign sel    = tle_pkg::vtx_sel(cnt_q);
  assign base_x = tle_pkg::PIX_W'(sel.use_b ? item_q.bx : item_q.ax) <<< tle_pkg::PIX_SHIFT;
  assign base_y = tle_pkg::PIX_W'(sel.use_b ? item_q.by : item_q.ay) <<< tle_pkg::PIX_SHIFT;
  assign off_x  = tle_pkg::PIX_W'(item_q.ox);
  assign off_y  = tle_pkg::PIX_W'(item_q.oy);

  always_comb begin
    vtx_o.vx      = sel.plus ? base_x + off_x : base_x - off_x;
    vtx_o.vy      = sel.plus ? base_y + off_y : base_y - off_y;
    vtx_o.tri_idx = sel.tri_idx;
    vtx_o.corner  = sel.corner;
    vtx_o.degen   = item_q.degen;
    vtx_o.last    = sel.last;
  end

  assign valid_o = busy_q;

endmodule

`default_nettype wire
